### rtl/core/fpal_pkg.sv
// Shared types and constants for the two-page flash append log.
package fpal_pkg;

  localparam int unsigned SLOTS_PER_PAGE_DEFAULT = 256;
  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 48;

  // Operation codes carried in the input tuser
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // One command a cycle from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_RD_A0,
    CMD_RD_B0,
    CMD_CAP_B,
    CMD_SEARCH,
    CMD_PROBE,
    CMD_NARROW,
    CMD_FETCH,
    CMD_CAP_READ,
    CMD_INIT,
    CMD_PLACE,
    CMD_WRITE,
    CMD_ERASE,
    CMD_PUBLISH
  } cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic action;
    logic a_used;
    logic b_used;
    logic search_open;
    logic swapped;
    logic sweep_last;
  } status_t;

endpackage

### rtl/core/fpal_ctrl.sv
// Sequencing state machine for the two-page flash append log.
module fpal_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fpal_pkg::status_t st,
  output fpal_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CAP_B,
    S_DECIDE,
    S_PROBE,
    S_NARROW,
    S_CAPR,
    S_WRITE,
    S_ERASE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = fpal_pkg::CMD_IDLE;
    unique case (state)
      S_CLEAR: begin
        cmd = fpal_pkg::CMD_CLEAR;
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd        = fpal_pkg::CMD_LOAD;
          state_next = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd        = fpal_pkg::CMD_RD_A0;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd        = fpal_pkg::CMD_RD_B0;
        state_next = S_CAP_B;
      end
      S_CAP_B: begin
        cmd        = fpal_pkg::CMD_CAP_B;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!st.a_used && !st.b_used) begin
          if (st.action == fpal_pkg::ACT_READ) begin
            cmd        = fpal_pkg::CMD_INIT;
            state_next = S_DONE;
          end else begin
            cmd        = fpal_pkg::CMD_PLACE;
            state_next = S_WRITE;
          end
        end else begin
          cmd        = fpal_pkg::CMD_SEARCH;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (st.search_open) begin
          cmd        = fpal_pkg::CMD_PROBE;
          state_next = S_NARROW;
        end else if (st.action == fpal_pkg::ACT_READ) begin
          cmd        = fpal_pkg::CMD_FETCH;
          state_next = S_CAPR;
        end else begin
          cmd        = fpal_pkg::CMD_PLACE;
          state_next = S_WRITE;
        end
      end
      S_NARROW: begin
        cmd        = fpal_pkg::CMD_NARROW;
        state_next = S_PROBE;
      end
      S_CAPR: begin
        cmd        = fpal_pkg::CMD_CAP_READ;
        state_next = S_DONE;
      end
      S_WRITE: begin
        cmd        = fpal_pkg::CMD_WRITE;
        state_next = st.swapped ? S_ERASE : S_DONE;
      end
      S_ERASE: begin
        cmd = fpal_pkg::CMD_ERASE;
        if (st.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        // hold the finished word until the output register is free
        if (!out_valid || out_ready) begin
          cmd        = fpal_pkg::CMD_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == fpal_pkg::CMD_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/fpal_dp.sv
// Page memory, binary search registers and result registers of the append log.
module fpal_dp #(
  parameter int unsigned SLOTS_PER_PAGE = fpal_pkg::SLOTS_PER_PAGE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  fpal_pkg::cmd_t    cmd,
  input  logic              in_action,
  input  logic [31:0]       in_value,
  output fpal_pkg::status_t st,
  output logic [31:0]       latest_value,
  output logic              active_page,
  output logic [7:0]        latest_slot,
  output logic              page_swapped,
  output logic              initialized
);

  localparam int unsigned SW = $clog2(SLOTS_PER_PAGE);
  localparam int unsigned HW = $clog2(SLOTS_PER_PAGE + 1);
  localparam int unsigned AW = $clog2(2 * SLOTS_PER_PAGE);
  localparam int unsigned DEPTH = 2 * SLOTS_PER_PAGE;
  localparam logic [AW-1:0] PAGE_B_BASE = AW'(SLOTS_PER_PAGE);
  localparam logic [AW-1:0] CLEAR_LAST  = AW'(2 * SLOTS_PER_PAGE - 1);
  localparam logic [AW-1:0] ERASE_LAST  = AW'(SLOTS_PER_PAGE - 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;

  logic          action;
  logic [31:0]   value;
  logic          a_used;
  logic          b_used;
  logic [SW-1:0] lo;
  logic [HW-1:0] hi;
  logic [AW-1:0] sweep;

  logic          page;
  logic [SW-1:0] slot;
  logic [31:0]   latest;
  logic          swapped;
  logic          inited;

  logic [HW:0]   mid_sum;
  logic [SW-1:0] mid;
  logic [HW-1:0] span;
  logic [HW-1:0] lo_inc;
  logic [SW+7:0] slot_ext;
  logic          rd_erased;

  function automatic logic [AW-1:0] addr_of(input logic pg, input logic [SW-1:0] sl);
    addr_of = pg ? PAGE_B_BASE + AW'(sl) : AW'(sl);
  endfunction

  assign mid_sum   = {1'b0, hi} + (HW + 1)'(lo);
  assign mid       = mid_sum[SW:1];
  assign span      = hi - HW'(lo);
  assign lo_inc    = HW'(lo) + HW'(1);
  assign rd_erased = (rdata == fpal_pkg::ERASED_WORD);

  assign st.action      = action;
  assign st.a_used      = a_used;
  assign st.b_used      = b_used;
  assign st.search_open = (span > HW'(1));
  assign st.swapped     = swapped;
  assign st.sweep_last  = (cmd == fpal_pkg::CMD_CLEAR) ? (sweep == CLEAR_LAST)
                                                       : (sweep == ERASE_LAST);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = fpal_pkg::ERASED_WORD;
    unique case (cmd)
      fpal_pkg::CMD_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep;
      end
      fpal_pkg::CMD_RD_A0: mem_addr = addr_of(1'b0, '0);
      fpal_pkg::CMD_RD_B0: mem_addr = addr_of(1'b1, '0);
      fpal_pkg::CMD_PROBE: mem_addr = addr_of(page, mid);
      fpal_pkg::CMD_FETCH: mem_addr = addr_of(page, lo);
      fpal_pkg::CMD_INIT: begin
        // both pages are already blank here, so only the zero word is stored
        mem_we    = 1'b1;
        mem_addr  = addr_of(1'b0, '0);
        mem_wdata = '0;
      end
      fpal_pkg::CMD_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = addr_of(page, slot);
        mem_wdata = value;
      end
      fpal_pkg::CMD_ERASE: begin
        mem_we   = 1'b1;
        mem_addr = addr_of(~page, sweep[SW-1:0]);
      end
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd == fpal_pkg::CMD_CLEAR || cmd == fpal_pkg::CMD_ERASE) begin
      sweep <= sweep + AW'(1);
    end else if (cmd == fpal_pkg::CMD_LOAD) begin
      sweep <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      fpal_pkg::CMD_LOAD: begin
        action <= in_action;
        value  <= in_value;
      end
      fpal_pkg::CMD_RD_B0: a_used <= !rd_erased;
      fpal_pkg::CMD_CAP_B: b_used <= !rd_erased;
      fpal_pkg::CMD_SEARCH: begin
        lo   <= '0;
        hi   <= HW'(SLOTS_PER_PAGE);
        page <= !a_used;
      end
      fpal_pkg::CMD_NARROW: begin
        if (rd_erased) begin
          hi <= HW'(mid);
        end else begin
          lo <= mid;
        end
      end
      fpal_pkg::CMD_CAP_READ: begin
        latest  <= rdata;
        slot    <= lo;
        swapped <= 1'b0;
        inited  <= 1'b0;
      end
      fpal_pkg::CMD_INIT: begin
        latest  <= '0;
        page    <= 1'b0;
        slot    <= '0;
        swapped <= 1'b0;
        inited  <= 1'b1;
      end
      fpal_pkg::CMD_PLACE: begin
        latest <= value;
        inited <= 1'b0;
        if (!a_used && !b_used) begin
          page    <= 1'b0;
          slot    <= '0;
          swapped <= 1'b0;
        end else if (lo_inc < HW'(SLOTS_PER_PAGE)) begin
          slot    <= lo_inc[SW-1:0];
          swapped <= 1'b0;
        end else begin
          // page full: move to the other page, the old one is erased after
          page    <= ~page;
          slot    <= '0;
          swapped <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign slot_ext = {8'b0, slot};

  always_ff @(posedge clk) begin
    if (cmd == fpal_pkg::CMD_PUBLISH) begin
      latest_value <= latest;
      active_page  <= page;
      latest_slot  <= slot_ext[7:0];
      page_swapped <= swapped;
      initialized  <= inited;
    end
  end

endmodule

### rtl/core/two_page_flash_append_log.sv
// Top level of the two-page flash append log.
//
// Keeps one 32-bit value as an append-only log over two pages of
// SLOTS_PER_PAGE words each, an erased word being all ones.
// Input channel s_axis: tuser carries the action (read or append), tdata the
// word to append. Output channel m_axis: one word per input word, giving the
// latest value, its page and slot, and the swap and initialise flags.
// One word is worked on at a time; s_axis_tready is high only while idle.
// Per word: the first words of both pages are read, then a binary search of
// at most ceil(log2 N) probes (N = SLOTS_PER_PAGE, 8 for 256 slots) finds
// the last written slot of the active page; a read fetches that slot and an
// append writes the slot after it. The result is then loaded into the output
// register, and the next word can be taken in the cycle after. A full page
// moves the append to slot 0 of the other page and erases the old page, one
// word a cycle. Both-pages-blank cases skip the search. Each probe is one
// memory read and one compare. After reset the memory is swept to all ones
// before the first word is taken. The result sits in an output register;
// while the receiver stalls the next word may still be taken and worked on,
// and it waits at the end until the register is free.
module two_page_flash_append_log #(
  parameter int unsigned SLOTS_PER_PAGE = fpal_pkg::SLOTS_PER_PAGE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] write_value
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [31:0] latest_value, [32] active_page,
                                      // [40:33] latest_slot, [41] page_swapped,
                                      // [42] initialized, [47:43] zero
);

  fpal_pkg::cmd_t    cmd;
  fpal_pkg::status_t st;

  logic [31:0] latest_value;
  logic        active_page;
  logic [7:0]  latest_slot;
  logic        page_swapped;
  logic        initialized;

  fpal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fpal_dp #(
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_action    (s_axis_tuser[0]),
    .in_value     (s_axis_tdata),
    .st           (st),
    .latest_value (latest_value),
    .active_page  (active_page),
    .latest_slot  (latest_slot),
    .page_swapped (page_swapped),
    .initialized  (initialized)
  );

  assign m_axis_tdata = {5'b0, initialized, page_swapped, latest_slot, active_page,
                         latest_value};

  // a result is never overwritten before the receiver takes it
  assert property (@(posedge clk) disable iff (rst)
    cmd == fpal_pkg::CMD_PUBLISH |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while stalled");

  // a word is loaded only on an accepted input handshake
  assert property (@(posedge clk) disable iff (rst)
    cmd == fpal_pkg::CMD_LOAD |-> (s_axis_tvalid && s_axis_tready))
    else $error("input loaded without handshake");

  // a page swap always lands on slot 0 of the other page
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && page_swapped) |-> (latest_slot == 8'd0 && !initialized))
    else $error("swap result not at slot 0");

  // initialisation reports zero at page A slot 0
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && initialized) |->
      (latest_value == 32'd0 && !active_page && latest_slot == 8'd0))
    else $error("bad initialisation result");

endmodule
